// ===== design/pmi_pkg.sv =====
// pmi_pkg: shared types, constants and the operation schedule of the particle integrator
// used by pmi_seq, pmi_mac and particle_motion_integrate; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package pmi_pkg;

  localparam int MAX_PARTICLES_DEF = 4096;
  localparam int DATA_W            = 32;
  localparam int AGE_W             = 31;
  localparam int FRAC_W            = 16;
  localparam int PROD_W            = 2 * DATA_W;
  localparam int CFG_ADDR_W        = 2;
  localparam int STEP_W            = 4;

  // schedule positions
  localparam int FIRST_OP        = 0;
  localparam int FIRST_MOTION_OP = 7;
  localparam int LAST_OP         = 10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_DRAG      = 2'd1,
    CFG_GRAVITY   = 2'd2,
    CFG_SKIP      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } seq_state_t;

  // working registers of one particle
  typedef enum logic [3:0] {
    R_VX,
    R_VY,
    R_VZ,
    R_PX,
    R_PY,
    R_PZ,
    R_ANG,
    R_SPIN,
    R_T0,
    R_T1,
    R_T2,
    R_GRAV
  } reg_sel_t;

  typedef struct packed {
    reg_sel_t src;
    logic     use_drag;
    logic     accum;
    reg_sel_t dst;
  } op_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } seq_ctrl_t;

  typedef struct packed {
    logic     vld;
    logic     accum;
    reg_sel_t dst;
  } mac_req_t;

  // dst <= (accum ? dst : 0) + src * (use_drag ? drag : dt)
  // spacing keeps every read after the write-back it depends on
  function automatic op_t sched(logic [STEP_W-1:0] step);
    op_t op;
    case (step)
      4'd0:    op = '{src: R_VX,   use_drag: 1'b1, accum: 1'b0, dst: R_T0};
      4'd1:    op = '{src: R_VY,   use_drag: 1'b1, accum: 1'b0, dst: R_T1};
      4'd2:    op = '{src: R_VZ,   use_drag: 1'b1, accum: 1'b0, dst: R_T2};
      4'd3:    op = '{src: R_T0,   use_drag: 1'b0, accum: 1'b1, dst: R_VX};
      4'd4:    op = '{src: R_T1,   use_drag: 1'b0, accum: 1'b1, dst: R_VY};
      4'd5:    op = '{src: R_T2,   use_drag: 1'b0, accum: 1'b1, dst: R_VZ};
      4'd6:    op = '{src: R_GRAV, use_drag: 1'b0, accum: 1'b1, dst: R_VY};
      4'd7:    op = '{src: R_VX,   use_drag: 1'b0, accum: 1'b1, dst: R_PX};
      4'd8:    op = '{src: R_VY,   use_drag: 1'b0, accum: 1'b1, dst: R_PY};
      4'd9:    op = '{src: R_VZ,   use_drag: 1'b0, accum: 1'b1, dst: R_PZ};
      default: op = '{src: R_SPIN, use_drag: 1'b0, accum: 1'b1, dst: R_ANG};
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ===== design/pmi_mac.sv =====
// pmi_mac: shared q16.16 multiply with floor, saturation and saturating accumulate
// two stages: registered 32x32 product, then shift, clamp and add; uses pmi_pkg
`timescale 1ns / 1ps
`default_nettype none

module pmi_mac (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire pmi_pkg::mac_req_t                req,
  input  wire logic signed [pmi_pkg::DATA_W-1:0] op_a,
  input  wire logic signed [pmi_pkg::DATA_W-1:0] op_b,
  input  wire logic signed [pmi_pkg::DATA_W-1:0] acc,
  output pmi_pkg::mac_req_t                     res,
  output logic signed [pmi_pkg::DATA_W-1:0]     res_val
);

  localparam int DW = pmi_pkg::DATA_W;
  localparam int PW = pmi_pkg::PROD_W;
  localparam int FW = pmi_pkg::FRAC_W;
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [PW-1:0] prod_r;
  pmi_pkg::mac_req_t    req_r;

  logic signed [PW-1:0] shifted;
  logic [PW-FW-DW:0]    top_bits;
  logic                 ovf;
  logic signed [DW-1:0] q;
  logic signed [DW:0]   sum;
  logic signed [DW-1:0] sum_sat;

  always_ff @(posedge clk) begin
    prod_r <= PW'(op_a) * PW'(op_b);
    if (!rst_n) begin
      req_r <= '0;
    end else begin
      req_r <= req;
    end
  end

  always_comb begin
    // arithmetic shift is floor toward minus infinity
    shifted  = prod_r >>> FW;
    top_bits = shifted[PW-FW-1:DW-1];
    ovf      = !((&top_bits) || (top_bits == '0));
    if (ovf) begin
      q = prod_r[PW-1] ? SMIN : SMAX;
    end else begin
      q = shifted[DW-1:0];
    end
    sum = {acc[DW-1], acc} + {q[DW-1], q};
    if (sum[DW] != sum[DW-1]) begin
      sum_sat = sum[DW] ? SMIN : SMAX;
    end else begin
      sum_sat = sum[DW-1:0];
    end
    res_val = req_r.accum ? sum_sat : q;
    res     = req_r;
  end

endmodule

`default_nettype wire

// ===== design/pmi_seq.sv =====
// pmi_seq: sequencer that walks the operation schedule for one particle
// drives the load, issue and finish strobes; uses pmi_pkg
`timescale 1ns / 1ps
`default_nettype none

module pmi_seq (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         skip,
  input  wire logic         out_free,
  output logic              busy,
  output pmi_pkg::seq_ctrl_t ctrl,
  output pmi_pkg::op_t      op
);

  localparam int SW = pmi_pkg::STEP_W;
  localparam logic [SW-1:0] STEP_FIRST  = SW'(pmi_pkg::FIRST_OP);
  localparam logic [SW-1:0] STEP_MOTION = SW'(pmi_pkg::FIRST_MOTION_OP);
  localparam logic [SW-1:0] STEP_LAST   = SW'(pmi_pkg::LAST_OP);
  localparam logic [SW-1:0] STEP_DRAIN  = SW'(pmi_pkg::LAST_OP + 1);

  pmi_pkg::seq_state_t state_r, state_nxt;
  logic [SW-1:0]       step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmi_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      pmi_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pmi_pkg::ST_RUN;
          step_nxt  = skip ? STEP_MOTION : STEP_FIRST;
        end
      end
      pmi_pkg::ST_RUN: begin
        step_nxt = step_r + 1'b1;
        // last write-back lands in the drain step
        if (step_r == STEP_DRAIN) begin
          state_nxt = pmi_pkg::ST_DONE;
        end
      end
      pmi_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = pmi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pmi_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    op   = pmi_pkg::sched(step_r);
    case (state_r)
      pmi_pkg::ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = in_valid;
      end
      pmi_pkg::ST_RUN: begin
        ctrl.issue = (step_r <= STEP_LAST);
      end
      pmi_pkg::ST_DONE: begin
        ctrl.finish = out_free;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/particle_motion_integrate.sv =====
// particle_motion_integrate: euler step for one particle record per beat
// a beat is loaded into the working record, the schedule runs, then the result is registered
// a new particle is taken only after the last result was handed on; eleven (or four with
//   skip_forces) multiplies run one after another on the single shared multiplier
// reset: synchronous active-low rst_n clears config, survivor count and handshake state
// depends on pmi_pkg, pmi_seq and pmi_mac
`timescale 1ns / 1ps
`default_nettype none

module particle_motion_integrate #(
  parameter int MAX_PARTICLES = pmi_pkg::MAX_PARTICLES_DEF,
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [pmi_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  wire logic [pmi_pkg::DATA_W-1:0]            cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_first_of_frame,
  input  wire logic [pmi_pkg::AGE_W-1:0]             in_age_in,
  input  wire logic [pmi_pkg::AGE_W-1:0]             in_lifetime_in,
  input  wire logic signed [pmi_pkg::DATA_W-1:0]     in_pos_x_in,
  input  wire logic signed [pmi_pkg::DATA_W-1:0]     in_pos_y_in,
  input  wire logic signed [pmi_pkg::DATA_W-1:0]     in_pos_z_in,
  input  wire logic signed [pmi_pkg::DATA_W-1:0]     in_vel_x_in,
  input  wire logic signed [pmi_pkg::DATA_W-1:0]     in_vel_y_in,
  input  wire logic signed [pmi_pkg::DATA_W-1:0]     in_vel_z_in,
  input  wire logic signed [pmi_pkg::DATA_W-1:0]     in_angle_in,
  input  wire logic signed [pmi_pkg::DATA_W-1:0]     in_spin_in,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_alive,
  output logic [CNT_W-1:0]                           out_survivor_count,
  output logic [pmi_pkg::AGE_W-1:0]                  out_age_out,
  output logic [pmi_pkg::AGE_W-1:0]                  out_lifetime_out,
  output logic signed [pmi_pkg::DATA_W-1:0]          out_pos_x_out,
  output logic signed [pmi_pkg::DATA_W-1:0]          out_pos_y_out,
  output logic signed [pmi_pkg::DATA_W-1:0]          out_pos_z_out,
  output logic signed [pmi_pkg::DATA_W-1:0]          out_vel_x_out,
  output logic signed [pmi_pkg::DATA_W-1:0]          out_vel_y_out,
  output logic signed [pmi_pkg::DATA_W-1:0]          out_vel_z_out,
  output logic signed [pmi_pkg::DATA_W-1:0]          out_angle_out,
  output logic signed [pmi_pkg::DATA_W-1:0]          out_spin_out
);

  localparam int DW = pmi_pkg::DATA_W;
  localparam int AW = pmi_pkg::AGE_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES);

  // configuration
  logic [AW-1:0]        time_step_r;
  logic signed [DW-1:0] drag_r;
  logic signed [DW-1:0] grav_r;
  logic                 skip_r;

  // working record
  logic signed [DW-1:0] vx_r, vy_r, vz_r, px_r, py_r, pz_r, ang_r, spin_r;
  logic signed [DW-1:0] t0_r, t1_r, t2_r;
  logic [AW-1:0]        age_r, life_r;
  logic                 first_r;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt, cnt_base;
  logic                 out_valid_r;

  pmi_pkg::seq_ctrl_t   ctrl;
  pmi_pkg::op_t         op;
  pmi_pkg::mac_req_t    req, res;
  logic signed [DW-1:0] op_a, op_b, acc, res_val;
  logic                 busy, out_free, alive;
  logic [AW:0]          age_sum;
  logic [AW-1:0]        age_sat;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy;
  assign out_valid = out_valid_r;

  pmi_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .skip     (skip_r),
    .out_free (out_free),
    .busy     (busy),
    .ctrl     (ctrl),
    .op       (op)
  );

  function automatic logic signed [DW-1:0] pick(
    pmi_pkg::reg_sel_t s,
    logic signed [DW-1:0] vx, logic signed [DW-1:0] vy, logic signed [DW-1:0] vz,
    logic signed [DW-1:0] px, logic signed [DW-1:0] py, logic signed [DW-1:0] pz,
    logic signed [DW-1:0] ang, logic signed [DW-1:0] spin,
    logic signed [DW-1:0] t0, logic signed [DW-1:0] t1, logic signed [DW-1:0] t2,
    logic signed [DW-1:0] grav
  );
    logic signed [DW-1:0] v;
    case (s)
      pmi_pkg::R_VX:   v = vx;
      pmi_pkg::R_VY:   v = vy;
      pmi_pkg::R_VZ:   v = vz;
      pmi_pkg::R_PX:   v = px;
      pmi_pkg::R_PY:   v = py;
      pmi_pkg::R_PZ:   v = pz;
      pmi_pkg::R_ANG:  v = ang;
      pmi_pkg::R_SPIN: v = spin;
      pmi_pkg::R_T0:   v = t0;
      pmi_pkg::R_T1:   v = t1;
      pmi_pkg::R_T2:   v = t2;
      pmi_pkg::R_GRAV: v = grav;
      default:         v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    op_a = pick(op.src, vx_r, vy_r, vz_r, px_r, py_r, pz_r, ang_r, spin_r,
                t0_r, t1_r, t2_r, grav_r);
    op_b = op.use_drag ? drag_r : $signed({1'b0, time_step_r});
    req.vld   = ctrl.issue;
    req.accum = op.accum;
    req.dst   = op.dst;
    // accumulator follows the destination of the op in write-back
    acc = pick(res.dst, vx_r, vy_r, vz_r, px_r, py_r, pz_r, ang_r, spin_r,
               t0_r, t1_r, t2_r, grav_r);
  end

  pmi_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .op_a    (op_a),
    .op_b    (op_b),
    .acc     (acc),
    .res     (res),
    .res_val (res_val)
  );

  always_comb begin
    age_sum = {1'b0, in_age_in} + {1'b0, time_step_r};
    age_sat = age_sum[AW] ? {AW{1'b1}} : age_sum[AW-1:0];
    alive   = age_r < life_r;
    cnt_base = first_r ? '0 : cnt_r;
    cnt_nxt  = cnt_base;
    if (alive && (cnt_base < CNT_MAX)) begin
      cnt_nxt = cnt_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= '0;
      drag_r      <= '0;
      grav_r      <= '0;
      skip_r      <= 1'b0;
    end else if (cfg_we) begin
      case (pmi_pkg::cfg_idx_t'(cfg_addr))
        pmi_pkg::CFG_TIME_STEP: time_step_r <= cfg_wdata[AW-1:0];
        pmi_pkg::CFG_DRAG:      drag_r      <= $signed(cfg_wdata);
        pmi_pkg::CFG_GRAVITY:   grav_r      <= $signed(cfg_wdata);
        pmi_pkg::CFG_SKIP:      skip_r      <= cfg_wdata[0];
        default:                skip_r      <= skip_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      vx_r    <= in_vel_x_in;
      vy_r    <= in_vel_y_in;
      vz_r    <= in_vel_z_in;
      px_r    <= in_pos_x_in;
      py_r    <= in_pos_y_in;
      pz_r    <= in_pos_z_in;
      ang_r   <= in_angle_in;
      spin_r  <= in_spin_in;
      age_r   <= age_sat;
      life_r  <= in_lifetime_in;
      first_r <= in_first_of_frame;
    end else if (res.vld) begin
      case (res.dst)
        pmi_pkg::R_VX:  vx_r  <= res_val;
        pmi_pkg::R_VY:  vy_r  <= res_val;
        pmi_pkg::R_VZ:  vz_r  <= res_val;
        pmi_pkg::R_PX:  px_r  <= res_val;
        pmi_pkg::R_PY:  py_r  <= res_val;
        pmi_pkg::R_PZ:  pz_r  <= res_val;
        pmi_pkg::R_ANG: ang_r <= res_val;
        pmi_pkg::R_T0:  t0_r  <= res_val;
        pmi_pkg::R_T1:  t1_r  <= res_val;
        pmi_pkg::R_T2:  t2_r  <= res_val;
        default:        spin_r <= spin_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.finish) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_alive          <= alive;
      out_survivor_count <= cnt_nxt;
      out_age_out        <= age_r;
      out_lifetime_out   <= life_r;
      out_pos_x_out      <= px_r;
      out_pos_y_out      <= py_r;
      out_pos_z_out      <= pz_r;
      out_vel_x_out      <= vx_r;
      out_vel_y_out      <= vy_r;
      out_vel_z_out      <= vz_r;
      out_angle_out      <= ang_r;
      out_spin_out       <= spin_r;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_survivor_count <= CNT_MAX))
    else $error("survivor count above limit");

  a_alive_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_alive == (out_age_out < out_lifetime_out)))
    else $error("alive flag disagrees with age and lifetime");

  a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> in_stall)
    else $error("write-back while idle");

  a_finish_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |-> (!res.vld && !ctrl.issue))
    else $error("result taken while multiplier still busy");

  a_load_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |=> (in_stall && !out_valid_r) || in_stall)
    else $error("input taken without going busy");
`endif

endmodule

`default_nettype wire
